// ----- sv/usm5_pkg.sv -----
// usm5_pkg: shared types and constants of the 5x5 unsharp-mask filter.
// Holds the configuration register codes, reset values, kernel taps and divider constants.
// No dependencies.
package usm5_pkg;

    // pixel and channel sizes
    localparam int C_CHAN_W  = 8;
    localparam int C_NUM_CH  = 4;
    localparam int C_PIXEL_W = C_CHAN_W * C_NUM_CH;

    // configuration port
    localparam int C_CFG_IDX_W  = 2;
    localparam int C_CFG_DATA_W = 11;
    localparam int C_GEOM_W     = 11;
    localparam int C_STRENGTH_W = 10;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_STRENGTH     = 2'd2
    } t_cfg_reg;

    // geometry limits and reset values
    localparam int C_MAX_WIDTH      = 1024;
    localparam int C_MAX_HEIGHT     = 1024;
    localparam int C_RESET_WIDTH    = 640;
    localparam int C_RESET_HEIGHT   = 480;
    localparam int C_RESET_STRENGTH = 256;

    // kernel, row-major, oldest row first
    localparam int C_KSIZE = 5;
    typedef logic [5:0] t_tap;
    localparam t_tap C_TAPS [C_KSIZE*C_KSIZE] = '{
        6'd0,  6'd0,  6'd1,  6'd0,  6'd0,
        6'd0,  6'd8,  6'd21, 6'd8,  6'd0,
        6'd1,  6'd21, 6'd59, 6'd21, 6'd1,
        6'd0,  6'd8,  6'd21, 6'd8,  6'd0,
        6'd0,  6'd0,  6'd1,  6'd0,  6'd0
    };

    // weighted sum fits 179*255; divide by 179 as multiply by ceil(2^24/179)
    localparam int C_SUM_W = 16;
    localparam int C_DIV_ROUND = 89;
    localparam int C_DIV_MUL_W = 17;
    localparam logic [C_DIV_MUL_W-1:0] C_DIV_MULT = 17'd93728;
    localparam int C_DIV_SHIFT = 24;

endpackage

// ----- sv/usm5_ram.sv -----
// usm5_ram: generic simple dual-port RAM, one write and one registered read port.
// Used for the line stores and the pixel history. No dependencies.
module usm5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/unsharp_mask_5x5_filter.sv -----
// unsharp_mask_5x5_filter: streaming 5x5 unsharp mask for raster-order RGBA pixels.
// Depends on usm5_pkg and usm5_ram (four line stores, one pixel history).
//
//  channel   | signals                                         | direction
//  ----------+-------------------------------------------------+----------
//  pixel in  | i_valid, o_stall, i_red/green/blue/alpha, i_flush | in
//  pixel out | o_valid, i_stall, o_out_red/green/blue/alpha,     | out
//            | o_last_pixel                                    |
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// One request is taken per clock while o_stall is low; results then pass through the registered
// history/line RAM read, window, kernel sum, divide, blend products and clamp stages.
// Output k of a frame is caused by input k + 2*W + 2; after a frame's last input, further
// requests, flush or not, drain the rest. Reset is synchronous, active low, clears
// counters and valids and resets the config registers. A stall on the output backs up stage by
// stage; o_stall rises only once the first stage cannot move on. Config is always ready.
module unsharp_mask_5x5_filter #(
    parameter int MAX_WIDTH  = usm5_pkg::C_MAX_WIDTH,
    parameter int MAX_HEIGHT = usm5_pkg::C_MAX_HEIGHT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // pixel in
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_alpha,
    input  logic       i_flush,
    // pixel out
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha,
    output logic       o_last_pixel,
    // config
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [usm5_pkg::C_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [usm5_pkg::C_CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int PW  = WW + HW;
    localparam int HD  = 2 ** $clog2(2 * MAX_WIDTH + 3);
    localparam int HAW = $clog2(HD);
    localparam int PXW = usm5_pkg::C_PIXEL_W;
    localparam int CHW = usm5_pkg::C_CHAN_W;
    localparam int NCH = usm5_pkg::C_NUM_CH;
    localparam int KS  = usm5_pkg::C_KSIZE;
    localparam int SW  = usm5_pkg::C_SUM_W;
    localparam int STW = usm5_pkg::C_STRENGTH_W;
    localparam int RST_W = (usm5_pkg::C_RESET_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : usm5_pkg::C_RESET_WIDTH;
    localparam int RST_H = (usm5_pkg::C_RESET_HEIGHT > MAX_HEIGHT) ?
                           MAX_HEIGHT : usm5_pkg::C_RESET_HEIGHT;

    // ---------------- configuration and frame counters ----------------
    logic [WW-1:0]  r_w;
    logic [HW-1:0]  r_h;
    logic [STW-1:0] r_strength;
    logic [PW-1:0]  r_rcv, r_sent;
    logic [CW-1:0]  r_icol, r_ocol;
    logic [RW-1:0]  r_orow;
    logic [HAW-1:0] r_wp, r_rp;

    logic [WW-1:0]  n_w;
    logic [HW-1:0]  n_h;
    logic [PW-1:0]  c_total, c_rcv_inc, c_gap;
    logic [PW:0]    c_thresh;
    logic           c_in_done, c_all_sent, c_is_pix, c_emit, c_last, c_inner;
    logic           c_acc, c_cfg_wr;

    // saturate written geometry: zero acts as one, large values clip
    always_comb begin
        if (i_cfg_data == '0) begin
            n_w = WW'(1);
            n_h = HW'(1);
        end else begin
            n_w = (int'(i_cfg_data) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(i_cfg_data);
            n_h = (int'(i_cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(i_cfg_data);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign c_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // decide what the request does
    assign c_total    = {{HW{1'b0}}, r_w} * {{WW{1'b0}}, r_h};
    assign c_in_done  = (r_rcv >= c_total);
    assign c_all_sent = (r_sent >= c_total);
    assign c_is_pix   = !c_in_done && !i_flush;
    assign c_rcv_inc  = r_rcv + PW'(1);
    assign c_gap      = c_rcv_inc - r_sent;
    assign c_thresh   = (PW+1)'({r_w, 1'b0}) + (PW+1)'(2);
    assign c_emit     = c_in_done ? !c_all_sent : (c_is_pix && ({1'b0, c_gap} > c_thresh));
    assign c_last     = (r_sent == c_total - PW'(1));
    assign c_inner    = (r_ocol >= CW'(2)) && ((WW+1)'(r_ocol) + (WW+1)'(2) < (WW+1)'(r_w))
                     && (r_orow >= RW'(2)) && ((HW+1)'(r_orow) + (HW+1)'(2) < (HW+1)'(r_h));
    assign c_acc      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WW'(RST_W);
            r_h <= HW'(RST_H);
            r_strength <= STW'(usm5_pkg::C_RESET_STRENGTH);
            r_rcv <= '0;
            r_sent <= '0;
            r_icol <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_wp <= '0;
            r_rp <= '0;
        end else if (c_cfg_wr) begin
            case (i_cfg_index)
                usm5_pkg::CFG_IMAGE_WIDTH, usm5_pkg::CFG_IMAGE_HEIGHT: begin
                    if (i_cfg_index == usm5_pkg::CFG_IMAGE_WIDTH) begin
                        r_w <= n_w;
                    end else begin
                        r_h <= n_h;
                    end
                    // restart the frame and drop held-back pixels
                    r_rcv <= '0;
                    r_sent <= '0;
                    r_icol <= '0;
                    r_ocol <= '0;
                    r_orow <= '0;
                    r_rp <= r_wp;
                end
                usm5_pkg::CFG_STRENGTH: begin
                    r_strength <= i_cfg_data[STW-1:0];
                end
                default: begin
                end
            endcase
        end else if (c_acc) begin
            if (c_is_pix) begin
                r_rcv <= c_rcv_inc;
                r_wp <= r_wp + HAW'(1);
                if (WW'(r_icol) + WW'(1) >= r_w) begin
                    r_icol <= '0;
                end else begin
                    r_icol <= r_icol + CW'(1);
                end
            end
            if (c_emit) begin
                r_rp <= r_rp + HAW'(1);
                if (c_last) begin
                    r_rcv <= '0;
                    r_sent <= '0;
                    r_icol <= '0;
                    r_ocol <= '0;
                    r_orow <= '0;
                end else begin
                    r_sent <= r_sent + PW'(1);
                    if (WW'(r_ocol) + WW'(1) >= r_w) begin
                        r_ocol <= '0;
                        r_orow <= r_orow + RW'(1);
                    end else begin
                        r_ocol <= r_ocol + CW'(1);
                    end
                end
            end
        end
    end

    // ---------------- pipeline handshake ----------------
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_o_v;
    logic s1_go, s2_go, s3_go, s4_go, s5_go;
    logic s2_free, s3_free, s4_free, s5_free, o_free, s1_ld;

    assign o_free  = !r_o_v || !i_stall;
    assign s5_go   = r_s5_v && o_free;
    assign s5_free = !r_s5_v || s5_go;
    assign s4_go   = r_s4_v && s5_free;
    assign s4_free = !r_s4_v || s4_go;
    assign s3_go   = r_s3_v && s4_free;
    assign s3_free = !r_s3_v || s3_go;
    assign s2_go   = r_s2_v && s3_free;
    assign s2_free = !r_s2_v || s2_go;
    assign s1_go   = r_s1_v && s2_free;
    assign o_stall = r_s1_v && !s1_go;
    assign s1_ld   = c_acc && (c_is_pix || c_emit);

    // ---------------- memories ----------------
    logic [PXW-1:0] c_in_px, c_hist_rd;
    logic [PXW-1:0] c_line_rd [4];
    logic [PXW-1:0] c_line_wd [4];
    logic           c_line_we;

    assign c_in_px = {i_alpha, i_blue, i_green, i_red};

    // pixel history: centre pixel of every result
    usm5_ram #(.WIDTH(PXW), .DEPTH(HD)) u_hist (
        .i_clk   (i_clk),
        .i_we    (c_acc && c_is_pix),
        .i_waddr (r_wp),
        .i_wdata (c_in_px),
        .i_re    (c_acc && c_emit),
        .i_raddr (r_rp),
        .o_rdata (c_hist_rd)
    );

    // stage 1 registers
    logic           r_s1_pix, r_s1_emit, r_s1_inner, r_s1_last;
    logic [PXW-1:0] r_s1_px;
    logic [CW-1:0]  r_s1_col;

    // line stores cascade: store k holds row y-1-k at each column
    assign c_line_we = s1_go && r_s1_pix;
    assign c_line_wd[0] = r_s1_px;
    assign c_line_wd[1] = c_line_rd[0];
    assign c_line_wd[2] = c_line_rd[1];
    assign c_line_wd[3] = c_line_rd[2];

    for (genvar g = 0; g < 4; g++) begin : g_line
        usm5_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_line (
            .i_clk   (i_clk),
            .i_we    (c_line_we),
            .i_waddr (r_s1_col),
            .i_wdata (c_line_wd[g]),
            .i_re    (c_acc && c_is_pix),
            .i_raddr (r_icol),
            .o_rdata (c_line_rd[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_ld) begin
            r_s1_v <= 1'b1;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ld) begin
            r_s1_pix <= c_is_pix;
            r_s1_emit <= c_emit;
            r_s1_inner <= c_inner;
            r_s1_last <= c_last;
            r_s1_px <= c_in_px;
            r_s1_col <= r_icol;
        end
    end

    // ---------------- stage 2: 5x5 window ----------------
    logic [PXW-1:0] r_win [KS][KS];
    logic [PXW-1:0] c_colv [KS];
    logic           r_s2_inner, r_s2_last;
    logic [PXW-1:0] r_s2_ctr;

    // newest column: oldest row first
    assign c_colv[0] = c_line_rd[3];
    assign c_colv[1] = c_line_rd[2];
    assign c_colv[2] = c_line_rd[1];
    assign c_colv[3] = c_line_rd[0];
    assign c_colv[4] = r_s1_px;

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_pix) begin
            for (int r = 0; r < KS; r++) begin
                for (int k = 0; k < KS - 1; k++) begin
                    r_win[r][k] <= r_win[r][k+1];
                end
                r_win[r][KS-1] <= c_colv[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s1_go && r_s1_emit) begin
            r_s2_v <= 1'b1;
        end else if (s2_go) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_emit) begin
            r_s2_inner <= r_s1_inner;
            r_s2_last <= r_s1_last;
            r_s2_ctr <= c_hist_rd;
        end
    end

    // ---------------- stage 3: kernel sums ----------------
    logic [SW-1:0]  c_sum [NCH];
    logic [SW-1:0]  r_s3_sum [NCH];
    logic           r_s3_inner, r_s3_last;
    logic [PXW-1:0] r_s3_ctr;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            c_sum[c] = '0;
            for (int r = 0; r < KS; r++) begin
                for (int k = 0; k < KS; k++) begin
                    c_sum[c] = c_sum[c]
                             + SW'(usm5_pkg::C_TAPS[r*KS+k]) * SW'(r_win[r][k][c*CHW +: CHW]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (s2_go) begin
            r_s3_v <= 1'b1;
        end else if (s3_go) begin
            r_s3_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_s3_sum <= c_sum;
            r_s3_inner <= r_s2_inner;
            r_s3_last <= r_s2_last;
            r_s3_ctr <= r_s2_ctr;
        end
    end

    // ---------------- stage 4: divide by 179, edge pass-through ----------------
    localparam int DMW = usm5_pkg::C_DIV_MUL_W;
    logic [CHW-1:0]     c_blur [NCH];
    logic [CHW-1:0]     r_s4_blur [NCH];
    logic [PXW-1:0]     r_s4_ctr;
    logic               r_s4_last;
    logic [2*DMW-1:0]   c_dprod [NCH];
    logic [2*DMW-usm5_pkg::C_DIV_SHIFT-1:0] c_quot [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            c_dprod[c] = (2*DMW)'((DMW'(r_s3_sum[c]) + DMW'(usm5_pkg::C_DIV_ROUND)))
                       * (2*DMW)'(usm5_pkg::C_DIV_MULT);
            c_quot[c] = c_dprod[c][2*DMW-1:usm5_pkg::C_DIV_SHIFT];
            if (!r_s3_inner) begin
                c_blur[c] = r_s3_ctr[c*CHW +: CHW];
            end else if (c_quot[c] > (2*DMW-usm5_pkg::C_DIV_SHIFT)'(255)) begin
                c_blur[c] = '1;
            end else begin
                c_blur[c] = c_quot[c][CHW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (s3_go) begin
            r_s4_v <= 1'b1;
        end else if (s4_go) begin
            r_s4_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_go) begin
            r_s4_blur <= c_blur;
            r_s4_ctr <= r_s3_ctr;
            r_s4_last <= r_s3_last;
        end
    end

    // ---------------- stage 5: blend products ----------------
    localparam int PSW = CHW + STW;
    localparam int PBW = CHW + 1 + STW + 1;
    logic signed [STW:0]   c_kb;
    logic [PSW-1:0]        r_s5_ps [NCH];
    logic signed [PBW-1:0] r_s5_pb [NCH];
    logic                  r_s5_last;

    // weight of the blurred value, 256 - s, may go negative
    assign c_kb = $signed((STW+1)'(256)) - $signed({1'b0, r_strength});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (s4_go) begin
            r_s5_v <= 1'b1;
        end else if (s5_go) begin
            r_s5_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_go) begin
            for (int c = 0; c < NCH; c++) begin
                r_s5_ps[c] <= PSW'(r_s4_ctr[c*CHW +: CHW]) * PSW'(r_strength);
                r_s5_pb[c] <= PBW'($signed({1'b0, r_s4_blur[c]})) * PBW'(c_kb);
            end
            r_s5_last <= r_s4_last;
        end
    end

    // ---------------- output: round, shift, clamp ----------------
    localparam int VW = PBW + 1;
    logic signed [VW-1:0] c_v [NCH];
    logic [CHW-1:0]       c_res [NCH];
    logic [CHW-1:0]       r_o_ch [NCH];
    logic                 r_o_last;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            c_v[c] = $signed(VW'(r_s5_ps[c])) + VW'(r_s5_pb[c]) + $signed(VW'(128));
            if (c_v[c] < 0) begin
                c_res[c] = '0;
            end else if (c_v[c][VW-2:CHW] > (VW-1-CHW)'(255)) begin
                c_res[c] = '1;
            end else begin
                c_res[c] = c_v[c][2*CHW-1:CHW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s5_go) begin
            r_o_v <= 1'b1;
        end else if (o_free) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s5_go) begin
            r_o_ch <= c_res;
            r_o_last <= r_s5_last;
        end
    end

    assign o_valid      = r_o_v;
    assign o_out_red    = r_o_ch[0];
    assign o_out_green  = r_o_ch[1];
    assign o_out_blue   = r_o_ch[2];
    assign o_out_alpha  = r_o_ch[3];
    assign o_last_pixel = r_o_last;

endmodule
